// File: src/octave_perlin_noise_3d_top_defines.svh
// Assertion macros for the octave noise block.
`ifndef OCTAVE_PERLIN_NOISE_3D_TOP_DEFINES_SVH
`define OCTAVE_PERLIN_NOISE_3D_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OPN_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("opn check failed");
`define OPN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("opn check failed");
`else
`define OPN_ASSERT_RST(lbl, prop)
`define OPN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/opn_pkg.sv
`default_nettype none
package opn_pkg;
	localparam int FRAC_W        = 16;
	localparam int TABLE_ENTRIES = 256;
	localparam int TAB_AW        = 8;
	localparam int MAX_OCTAVES   = 8;
	localparam int OCT_W         = 3;
	localparam int MUL_W         = 33;
	localparam int PROD_W        = 66;
	localparam int GRAD_W        = 19;
	localparam int SUM_W         = 27;
	localparam int NUM_W         = 27;
	localparam int DEN_W         = 9;
	localparam int NORM_W        = 19;
	localparam int SCALE_W       = 33;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_WRITE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_BASE_FREQ = 2'd0,
		REG_OCTAVES   = 2'd1,
		REG_RANGE_LO  = 2'd2,
		REG_RANGE_HI  = 2'd3
	} cfg_reg_t;

	typedef logic signed [GRAD_W-1:0] grad_t;

	// improved-noise gradient: pick two of the three offsets by the low hash nibble
	function automatic grad_t grad_f(input logic [7:0] h, input grad_t x, input grad_t y,
		input grad_t z);
		logic [3:0] k;
		grad_t gu;
		grad_t gv;
		grad_t ru;
		grad_t rv;
		k = h[3:0];
		gu = (k < 4'd8) ? x : y;
		if (k < 4'd4) begin
			gv = y;
		end else if (k == 4'd12 || k == 4'd14) begin
			gv = x;
		end else begin
			gv = z;
		end
		ru = k[0] ? -gu : gu;
		rv = k[1] ? -gv : gv;
		return ru + rv;
	endfunction
endpackage
`default_nettype wire

// File: src/opn_ram.sv
`default_nettype none
module opn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/octave_perlin_noise_3d_top.sv
// 3-D gradient noise summed over 1..8 octaves at one Q16.16 point, normalized and
// mapped into range_low..range_high. A table write word is taken in idle and leaves
// the block idle. A sample word occupies the block from its acceptance until its
// result is handed to the output: every product goes through one shared 33x33
// multiplier (the coordinates, the fades and the seven blends per octave), the hash
// table is read one byte a cycle, and the final normalization is a bit-serial divide.
// The table must be loaded before the first sample. A finished result is held on the
// output until taken while the next word is accepted; a sample that finishes while
// the previous result still waits on the output holds in its last cycle until that
// result is taken.
`default_nettype none
`include "octave_perlin_noise_3d_top_defines.svh"
module octave_perlin_noise_3d_top
	import opn_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// coord_x[31:0], coord_y[63:32], coord_z[95:64], table_index[103:96],
	// table_value[111:104]
	input  wire  [111:0] s_tdata,
	// operation[0]
	input  wire          s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// scaled_value[32:0], normalized_noise[51:33], zero pad[55:52]
	output logic [55:0]  m_tdata,
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [1:0]   cfg_index,
	input  wire  [31:0]  cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_COORD, ST_FADE, ST_HASH, ST_BLEND, ST_ACC, ST_PREP, ST_DIV,
		ST_MAP, ST_OUT
	} state_t;

	localparam logic [4:0] HASH_LAST  = 5'd14;
	localparam logic [4:0] BLEND_LAST = 5'd6;
	localparam logic [4:0] DIV_LAST   = 5'(NUM_W - 1);
	localparam logic [1:0] AX_LAST    = 2'd2;
	localparam logic [1:0] SUB_LAST   = 2'd2;

	state_t              state_q;
	logic                ph_q;
	logic [4:0]          cnt_q;
	logic [1:0]          ax_q;
	logic [1:0]          sub_q;
	logic [OCT_W-1:0]    oct_q;
	logic                m_tvalid_q;

	logic [31:0]         base_freq_q;
	logic [3:0]          octaves_q;
	logic [15:0]         range_lo_q;
	logic [15:0]         range_hi_q;

	logic signed [31:0]  cx_q, cy_q, cz_q;
	logic [63:0]         p_q [3];
	logic [16:0]         sq_q, cube_q;
	logic [16:0]         fade_q [3];
	logic [7:0]          a_q, b_q, aa_q, ab_q, ba_q, bb_q;
	grad_t               g_q [8];
	logic signed [SUM_W-1:0] acc_q;
	logic                neg_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    rem_q;
	logic signed [NORM_W-1:0]  norm_q;
	logic signed [SCALE_W-1:0] sc_q;
	logic [55:0]         m_tdata_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;

	logic                s_acc, tab_we;
	logic [TAB_AW-1:0]   tab_raddr, tab_rdata;
	logic [7:0]          cell_x, cell_y, cell_z;
	logic [63:0]         p_sel;
	logic [15:0]         t16;
	logic signed [MUL_W-1:0] t33;
	logic signed [22:0]  sq_e, t_e, inner;
	logic signed [31:0]  coord_sel;
	logic [16:0]         wsel;
	logic signed [MUL_W-1:0] diff33;
	logic [2:0]          widx, gsel;
	grad_t               x0, y0, z0, gx, gy, gz, blend_res;
	logic [3:0]          n_eff;
	logic                oct_last;
	logic [7:0]          dval;
	logic [DEN_W-1:0]    den;
	logic [SUM_W-1:0]    acc_abs;
	logic [DEN_W:0]      trial;
	logic                qbit;
	logic [17:0]         mag_sat;
	logic signed [NORM_W-1:0] norm_c;
	logic signed [16:0]  span;
	logic [16:0]         hl_sum;
	logic signed [39:0]  sum40, sc40;
	logic signed [SCALE_W-1:0] sc_sat;
	logic signed [NORM_W-1:0] out_norm;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign s_acc     = s_tvalid && s_tready;
	assign tab_we    = s_acc && (s_tuser == OP_WRITE);
	assign out_norm  = m_tdata[51:33];

	opn_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (s_tdata[103:96]),
		.wdata (s_tdata[111:104]),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q <= 32'd65536;
			octaves_q   <= 4'd4;
			range_lo_q  <= 16'd0;
			range_hi_q  <= 16'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_FREQ: base_freq_q <= cfg_data;
				REG_OCTAVES:   octaves_q   <= cfg_data[3:0];
				REG_RANGE_LO:  range_lo_q  <= cfg_data[15:0];
				REG_RANGE_HI:  range_hi_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// octave count clamp and divisor 2^n - 1
	assign n_eff = (octaves_q == 4'd0) ? 4'd1 :
		(octaves_q > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octaves_q;
	assign oct_last = (4'(oct_q) == n_eff - 4'd1);
	assign dval = 8'((9'd1 << n_eff) - 9'd1);
	assign den  = {dval, 1'b0};

	assign cell_x = p_q[0][39:32];
	assign cell_y = p_q[1][39:32];
	assign cell_z = p_q[2][39:32];
	assign p_sel  = p_q[ax_q];
	assign t16    = p_sel[31:16];
	assign t33    = {17'b0, t16};
	assign sq_e   = {6'b0, sq_q};
	assign t_e    = {7'b0, t16};
	assign inner  = sq_e * 23'sd6 - t_e * 23'sd15 + 23'sd655360;

	always_comb begin
		case (ax_q)
			2'd0:    coord_sel = cx_q;
			2'd1:    coord_sel = cy_q;
			default: coord_sel = cz_q;
		endcase
	end

	assign x0 = {3'b0, p_q[0][31:16]};
	assign y0 = {3'b0, p_q[1][31:16]};
	assign z0 = {3'b0, p_q[2][31:16]};
	assign gsel = 3'(cnt_q - 5'd7);
	assign gx = gsel[0] ? x0 - 19'sd65536 : x0;
	assign gy = gsel[1] ? y0 - 19'sd65536 : y0;
	assign gz = gsel[2] ? z0 - 19'sd65536 : z0;

	// blends pop the two head entries and push the result behind the live ones
	assign widx   = 3'(5'd6 - cnt_q);
	assign wsel   = (cnt_q < 5'd4) ? fade_q[0] : (cnt_q < 5'd6) ? fade_q[1] : fade_q[2];
	assign diff33 = {{14{g_q[1][GRAD_W-1]}}, g_q[1]} - {{14{g_q[0][GRAD_W-1]}}, g_q[0]};
	assign rnd    = (prod_s1 + 66'sd32768) >>> FRAC_W;
	assign blend_res = g_q[0] + rnd[GRAD_W-1:0];

	assign acc_abs = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : acc_q;
	assign trial   = {rem_q, num_q[NUM_W-1]};
	assign qbit    = (trial >= {1'b0, den});

	assign mag_sat = (num_q > 27'd131072) ? 18'd131072 : num_q[17:0];
	assign norm_c  = neg_q ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
	assign span    = $signed({1'b0, range_hi_q}) - $signed({1'b0, range_lo_q});
	assign hl_sum  = {1'b0, range_hi_q} + {1'b0, range_lo_q};
	assign sum40   = prod_s1[39:0] + $signed({7'b0, hl_sum, 16'b0}) + 40'sd1;
	assign sc40    = sum40 >>> 1;
	assign sc_sat  = (sc40 > 40'sd4294967295) ? 33'sh0FFFFFFFF :
		(sc40 < -40'sd4294967296) ? 33'sh100000000 : sc40[SCALE_W-1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_COORD: begin
				mul_a = {coord_sel[31], coord_sel};
				mul_b = {1'b0, base_freq_q};
			end
			ST_FADE: begin
				case (sub_q)
					2'd0: begin
						mul_a = t33;
						mul_b = t33;
					end
					2'd1: begin
						mul_a = {16'b0, sq_q};
						mul_b = t33;
					end
					default: begin
						mul_a = {16'b0, cube_q};
						mul_b = {{10{inner[22]}}, inner};
					end
				endcase
			end
			ST_BLEND: begin
				mul_a = diff33;
				mul_b = {16'b0, wsel};
			end
			ST_MAP: begin
				mul_a = {{14{norm_c[NORM_W-1]}}, norm_c};
				mul_b = {{16{span[16]}}, span};
			end
			default: ;
		endcase
	end

	always_comb begin
		case (cnt_q)
			5'd0:    tab_raddr = cell_x;
			5'd1:    tab_raddr = cell_x + 8'd1;
			5'd2:    tab_raddr = a_q;
			5'd3:    tab_raddr = a_q + 8'd1;
			5'd4:    tab_raddr = b_q;
			5'd5:    tab_raddr = b_q + 8'd1;
			5'd6:    tab_raddr = aa_q;
			5'd7:    tab_raddr = ba_q;
			5'd8:    tab_raddr = ab_q;
			5'd9:    tab_raddr = bb_q;
			5'd10:   tab_raddr = aa_q + 8'd1;
			5'd11:   tab_raddr = ba_q + 8'd1;
			5'd12:   tab_raddr = ab_q + 8'd1;
			5'd13:   tab_raddr = bb_q + 8'd1;
			default: tab_raddr = cell_x;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ph_q       <= 1'b0;
			cnt_q      <= '0;
			ax_q       <= '0;
			sub_q      <= '0;
			oct_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && s_tuser == OP_SAMPLE) begin
						state_q <= ST_COORD;
						ph_q    <= 1'b0;
						ax_q    <= '0;
						oct_q   <= '0;
					end
				end
				ST_COORD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (ax_q == AX_LAST) begin
							ax_q    <= '0;
							sub_q   <= '0;
							state_q <= ST_FADE;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end
				end
				ST_FADE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (sub_q == SUB_LAST) begin
							sub_q <= '0;
							if (ax_q == AX_LAST) begin
								ax_q    <= '0;
								cnt_q   <= '0;
								state_q <= ST_HASH;
							end else begin
								ax_q <= ax_q + 2'd1;
							end
						end else begin
							sub_q <= sub_q + 2'd1;
						end
					end
				end
				ST_HASH: begin
					if (cnt_q == HASH_LAST) begin
						cnt_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= ST_BLEND;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_BLEND: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (cnt_q == BLEND_LAST) begin
							cnt_q   <= '0;
							state_q <= ST_ACC;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_ACC: begin
					if (oct_last) begin
						state_q <= ST_PREP;
					end else begin
						oct_q   <= oct_q + 3'd1;
						ax_q    <= '0;
						sub_q   <= '0;
						state_q <= ST_FADE;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						cnt_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= ST_MAP;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_MAP: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the previous word has left the output register
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc) begin
			cx_q  <= s_tdata[31:0];
			cy_q  <= s_tdata[63:32];
			cz_q  <= s_tdata[95:64];
			acc_q <= '0;
		end
		case (state_q)
			ST_COORD: begin
				if (ph_q) begin
					p_q[ax_q] <= prod_s1[63:0];
				end
			end
			ST_FADE: begin
				if (ph_q) begin
					case (sub_q)
						2'd0:    sq_q         <= rnd[16:0];
						2'd1:    cube_q       <= rnd[16:0];
						default: fade_q[ax_q] <= rnd[16:0];
					endcase
				end
			end
			ST_HASH: begin
				case (cnt_q)
					5'd1: a_q  <= tab_rdata + cell_y;
					5'd2: b_q  <= tab_rdata + cell_y;
					5'd3: aa_q <= tab_rdata + cell_z;
					5'd4: ab_q <= tab_rdata + cell_z;
					5'd5: ba_q <= tab_rdata + cell_z;
					5'd6: bb_q <= tab_rdata + cell_z;
					default: begin
						if (cnt_q >= 5'd7) begin
							g_q[gsel] <= grad_f(tab_rdata, gx, gy, gz);
						end
					end
				endcase
			end
			ST_BLEND: begin
				if (ph_q) begin
					for (int i = 0; i < 8; i++) begin
						if (3'(i) == widx) begin
							g_q[i] <= blend_res;
						end else if (i < 6) begin
							g_q[i] <= g_q[3'(i + 2)];
						end
					end
				end
			end
			ST_ACC: begin
				acc_q <= (acc_q <<< 1) + {{(SUM_W-GRAD_W){g_q[0][GRAD_W-1]}}, g_q[0]};
				for (int i = 0; i < 3; i++) begin
					p_q[i] <= {p_q[i][62:0], 1'b0};
				end
			end
			ST_PREP: begin
				neg_q <= acc_q[SUM_W-1];
				num_q <= {acc_abs[NUM_W-2:0], 1'b0} + {19'b0, dval};
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], qbit};
			end
			ST_MAP: begin
				if (!ph_q) begin
					norm_q <= norm_c;
				end else begin
					sc_q <= sc_sat;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {4'b0, norm_q, sc_q};
				end
			end
			default: ;
		endcase
	end

	`OPN_ASSERT_NEXT(a_busy_after_sample, s_tvalid && s_tready && !s_tuser, !s_tready)
	`OPN_ASSERT_RST(a_norm_range, m_tvalid |-> (out_norm <= 19'sd131072 && out_norm >= -19'sd131072))
	`OPN_ASSERT_RST(a_octave_bound, (state_q != ST_IDLE) |-> (4'(oct_q) < n_eff))
endmodule
`default_nettype wire

// File: tb/tb_octave_perlin_noise_3d_top.sv
`default_nettype none
module tb_octave_perlin_noise_3d_top;
	import opn_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 450;

	class noise_scoreboard;
		bit [7:0]    perm[256];
		bit [31:0]   freq;
		bit [3:0]    octaves;
		bit [15:0]   lo_reg;
		bit [15:0]   hi_reg;
		bit [51:0]   pending[$];
		int          errors;

		function new();
			freq = 32'd65536;
			octaves = 4'd4;
			lo_reg = 16'd0;
			hi_reg = 16'd255;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, bit [31:0] val);
			case (idx)
				REG_BASE_FREQ: freq = val;
				REG_OCTAVES:   octaves = val[3:0];
				REG_RANGE_LO:  lo_reg = val[15:0];
				REG_RANGE_HI:  hi_reg = val[15:0];
				default: ;
			endcase
		endfunction

		function longint round_mul(longint v, longint w);
			return (v * w + 32768) >>> 16;
		endfunction

		function longint fade(longint t);
			longint sq;
			longint inner;
			longint cube;
			sq = round_mul(t, t);
			inner = 6 * sq - 15 * t + 10 * 65536;
			cube = round_mul(sq, t);
			return round_mul(cube, inner);
		endfunction

		function longint lerp(longint w, longint a, longint b);
			return a + round_mul(b - a, w);
		endfunction

		function longint gradient(int h, longint x, longint y, longint z);
			int k;
			longint gu;
			longint gv;
			k = h & 15;
			gu = (k < 8) ? x : y;
			gv = (k < 4) ? y : ((k == 12 || k == 14) ? x : z);
			return (k[0] ? -gu : gu) + (k[1] ? -gv : gv);
		endfunction

		function int look(int i);
			return perm[i & 255];
		endfunction

		function longint lattice_noise(bit [63:0] qx, bit [63:0] qy, bit [63:0] qz);
			int cx, cy, cz, a, b, aa, ab, ba, bb;
			longint x, y, z, u, v, w, x1, y1, z1;
			cx = qx[39:32];
			cy = qy[39:32];
			cz = qz[39:32];
			x = qx[31:16];
			y = qy[31:16];
			z = qz[31:16];
			u = fade(x);
			v = fade(y);
			w = fade(z);
			x1 = x - 65536;
			y1 = y - 65536;
			z1 = z - 65536;
			a = look(cx) + cy;
			aa = look(a) + cz;
			ab = look(a + 1) + cz;
			b = look(cx + 1) + cy;
			ba = look(b) + cz;
			bb = look(b + 1) + cz;
			return lerp(w,
				lerp(v, lerp(u, gradient(look(aa), x, y, z), gradient(look(ba), x1, y, z)),
					lerp(u, gradient(look(ab), x, y1, z), gradient(look(bb), x1, y1, z))),
				lerp(v, lerp(u, gradient(look(aa + 1), x, y, z1),
						gradient(look(ba + 1), x1, y, z1)),
					lerp(u, gradient(look(ab + 1), x, y1, z1),
						gradient(look(bb + 1), x1, y1, z1))));
		endfunction

		function void note_word(op_t op, bit [31:0] x, bit [31:0] y, bit [31:0] z,
			bit [7:0] idx, bit [7:0] val);
			int n;
			bit [63:0] px, py, pz;
			longint total, mag, norm, lo, hi, sc, d;
			bit [32:0] sc_bits;
			bit [18:0] norm_bits;
			if (op == OP_WRITE) begin
				perm[idx] = val;
				return;
			end
			n = octaves;
			if (n < 1) n = 1;
			if (n > 8) n = 8;
			px = {{32{x[31]}}, x} * {32'd0, freq};
			py = {{32{y[31]}}, y} * {32'd0, freq};
			pz = {{32{z[31]}}, z} * {32'd0, freq};
			total = 0;
			for (int i = 0; i < n; i++)
				total += lattice_noise(px << i, py << i, pz << i) * (longint'(1) << (n - 1 - i));
			d = (longint'(1) << n) - 1;
			mag = (2 * (total < 0 ? -total : total) + d) / (2 * d);
			norm = total < 0 ? -mag : mag;
			if (norm > 131072) norm = 131072;
			if (norm < -131072) norm = -131072;
			lo = lo_reg;
			hi = hi_reg;
			sc = (norm * (hi - lo) + (hi + lo) * 65536 + 1) >>> 1;
			if (sc > 64'sh0FFFFFFFF) sc = 64'sh0FFFFFFFF;
			if (sc < -64'sh100000000) sc = -64'sh100000000;
			sc_bits = sc[32:0];
			norm_bits = norm[18:0];
			pending.push_back({norm_bits, sc_bits});
		endfunction

		function void check_result(bit [55:0] word);
			bit [51:0] want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, word);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (word[32:0] !== want[32:0]) begin
				$display("%0t: scaled_value expected %h actual %h", $time, want[32:0],
					word[32:0]);
				errors++;
			end
			if (word[51:33] !== want[51:33]) begin
				$display("%0t: normalized_noise expected %h actual %h", $time, want[51:33],
					word[51:33]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	noise_scoreboard sb;
	bit  no_idle;
	int  hold_off;
	int  quiet_cycles;

	octave_perlin_noise_3d_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
			|| hold_off > 0) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_word(op_t op, bit [31:0] x, bit [31:0] y, bit [31:0] z,
		bit [7:0] idx, bit [7:0] val);
		if (!no_idle && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {val, idx, z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(op, x, y, z, idx, val);
	endtask

	task automatic sample(bit [31:0] x, bit [31:0] y, bit [31:0] z);
		send_word(OP_SAMPLE, x, y, z, 8'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic bit [31:0] rand_coord();
		bit [31:0] c;
		if ($urandom_range(0, 3) == 0) return $urandom;
		c = $urandom_range(0, 32'h003FFFFF);
		return $urandom_range(0, 1) ? -c : c;
	endfunction

	task automatic random_items(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 15)
				send_word(OP_WRITE, $urandom, $urandom, $urandom, 8'($urandom),
					8'($urandom));
			else
				sample(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	task automatic phase(bit [31:0] f, bit [31:0] n, bit [31:0] lo, bit [31:0] hi, int count);
		drain();
		write_reg(REG_BASE_FREQ, f);
		write_reg(REG_OCTAVES, n);
		write_reg(REG_RANGE_LO, lo);
		write_reg(REG_RANGE_HI, hi);
		random_items(count);
	endtask

	initial begin
		sb = new();
		no_idle = 1'b0;
		hold_off = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_SAMPLE;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_FREQ;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every table entry before the first sample
		for (int i = 0; i < 256; i++)
			send_word(OP_WRITE, $urandom, $urandom, $urandom, 8'(i), 8'($urandom));
		send_word(OP_WRITE, '1, '1, '1, 8'd0, 8'd255);
		send_word(OP_WRITE, '0, '0, '0, 8'd255, 8'd0);

		sample(32'd0, 32'd0, 32'd0);
		sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		sample(32'h80000000, 32'h80000000, 32'h80000000);
		sample(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		sample(32'h0000FFFF, 32'h00008000, 32'h00000001);
		sample(32'h00010000, 32'hFFFF0000, 32'h00FF0000);
		sample(32'h7FFFFFFF, 32'h80000000, 32'd0);
		sample(32'h00018000, 32'h00028000, 32'h00038000);
		random_items(110);

		// extreme frequency and full range, with a long receiver hold-off
		drain();
		write_reg(REG_BASE_FREQ, 32'hFFFFFFFF);
		write_reg(REG_OCTAVES, 32'd8);
		write_reg(REG_RANGE_LO, 32'd0);
		write_reg(REG_RANGE_HI, 32'd65535);
		hold_off = 1200;
		random_items(110);

		// zero octaves counts as one, inverted range, zero frequency
		phase(32'd0, 32'd0, 32'd65535, 32'd0, 60);
		phase(32'h00008000, 32'd15, 32'd1000, 32'd200, 100);
		no_idle = 1'b1;
		phase($urandom_range(0, 32'h00040000), 32'd1, $urandom_range(0, 65535),
			$urandom_range(0, 65535), 110);
		no_idle = 1'b0;
		phase(32'h00030000, 32'd9, 32'd0, 32'd0, 60);
		phase($urandom, 32'd3, 32'd65535, 32'd65535, 60);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
